>>> design/tmtw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared constants, command codes and status type for the text-mode terminal
// writer: field widths, control characters, operation codes.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int DEF_COLUMNS    = 80;
    localparam int DEF_ROWS       = 25;
    localparam int DEF_TAB_SPACES = 4;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int RD_ROW_W  = 5;
    localparam int RD_COL_W  = 7;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;
    localparam int ATTR_W    = 8;
    localparam int ENTRY_W   = ATTR_W + CHAR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam int CMD_W = 4;
    typedef logic [CMD_W-1:0] t_dp_cmd;

    localparam t_dp_cmd CMD_NOP    = 4'd0;
    localparam t_dp_cmd CMD_LATCH  = 4'd1;
    localparam t_dp_cmd CMD_CR     = 4'd2;
    localparam t_dp_cmd CMD_BS     = 4'd3;
    localparam t_dp_cmd CMD_BLANK  = 4'd4;
    localparam t_dp_cmd CMD_STORE  = 4'd5;
    localparam t_dp_cmd CMD_NL     = 4'd6;
    localparam t_dp_cmd CMD_SCROLL = 4'd7;
    localparam t_dp_cmd CMD_CLEAR  = 4'd8;
    localparam t_dp_cmd CMD_INIT   = 4'd9;
    localparam t_dp_cmd CMD_CAP    = 4'd10;
    localparam t_dp_cmd CMD_FIN    = 4'd11;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            is_nl;
        logic            is_cr;
        logic            is_bs;
        logic            at_origin;
        logic            at_last_col;
        logic            at_bottom;
        logic            cnt_one;
        logic            cnt_zero;
        logic            sweep_last;
        logic            scroll_last;
        logic            out_busy;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> design/text_mode_terminal_writer.sv
`default_nettype none
// After accept, carriage return, unused op and backspace at the origin go from
// decode straight to the result; a printable character adds a store step,
// backspace a blank step, newline the line-feed steps and cell read a read
// and a capture step. A new item is taken only once the last result is issued.
// A tab repeats the store step per space; a line wrap adds the line-feed steps.
// Scroll and clear sweep the store through the single write port. After reset the store is swept to blanks.
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character-cell terminal engine: screen store, cursor, put/clear/read items.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
    parameter int COLUMNS    = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS       = tmtw_pkg::DEF_ROWS,
    parameter int TAB_SPACES = tmtw_pkg::DEF_TAB_SPACES
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [tmtw_pkg::OP_W-1:0]      i_op,
    input  wire logic [tmtw_pkg::CHAR_W-1:0]    i_char_code,
    input  wire logic [tmtw_pkg::RD_ROW_W-1:0]  i_read_row,
    input  wire logic [tmtw_pkg::RD_COL_W-1:0]  i_read_col,
    input  wire logic                           i_cfg_we,
    input  wire logic [tmtw_pkg::ATTR_W-1:0]    i_cfg_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [tmtw_pkg::CUR_ROW_W-1:0] o_cursor_row,
    output logic      [tmtw_pkg::CUR_COL_W-1:0] o_cursor_col,
    output logic      [tmtw_pkg::ENTRY_W-1:0]   o_cell_entry,
    output logic                                o_scrolled
);

    import tmtw_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    tmtw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd),
        .i_stat     (dp_stat)
    );

    tmtw_datapath #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .TAB_SPACES (TAB_SPACES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_op         (i_op),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_entry (o_cell_entry),
        .o_scrolled   (o_scrolled)
    );

endmodule
`default_nettype wire

>>> design/tmtw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tmtw_ram #(
    parameter int WIDTH = tmtw_pkg::ENTRY_W,
    parameter int DEPTH = tmtw_pkg::DEF_ROWS * tmtw_pkg::DEF_COLUMNS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> design/tmtw_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_datapath
// Cursor, item and attribute registers, sweep counter, screen store and the
// output register of the terminal writer, driven by controller commands.
// ----------------------------------------------------------------------------
module tmtw_datapath #(
    parameter int COLUMNS    = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS       = tmtw_pkg::DEF_ROWS,
    parameter int TAB_SPACES = tmtw_pkg::DEF_TAB_SPACES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire tmtw_pkg::t_dp_cmd                i_cmd,
    output tmtw_pkg::t_dp_stat                    o_stat,
    input  wire logic [tmtw_pkg::OP_W-1:0]        i_op,
    input  wire logic [tmtw_pkg::CHAR_W-1:0]      i_char_code,
    input  wire logic [tmtw_pkg::RD_ROW_W-1:0]    i_read_row,
    input  wire logic [tmtw_pkg::RD_COL_W-1:0]    i_read_col,
    input  wire logic                             i_cfg_we,
    input  wire logic [tmtw_pkg::ATTR_W-1:0]      i_cfg_data,
    input  wire logic                             i_out_stall,
    output logic                                  o_out_valid,
    output logic      [tmtw_pkg::CUR_ROW_W-1:0]   o_cursor_row,
    output logic      [tmtw_pkg::CUR_COL_W-1:0]   o_cursor_col,
    output logic      [tmtw_pkg::ENTRY_W-1:0]     o_cell_entry,
    output logic                                  o_scrolled
);

    import tmtw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = $clog2(CELLS);
    localparam int IW    = $clog2(CELLS + 1);
    localparam int NW    = $clog2(TAB_SPACES + 1);

    // item registers
    logic [OP_W-1:0]     r_op;
    logic [CHAR_W-1:0]   r_char;
    logic [RD_ROW_W-1:0] r_rrow;
    logic [RD_COL_W-1:0] r_rcol;

    // control registers
    logic [NW-1:0]       r_cnt;
    logic [RW-1:0]       r_row;
    logic [CW-1:0]       r_col;
    logic [IW-1:0]       r_idx;
    logic                r_scr;
    logic [ATTR_W-1:0]   r_attr;
    logic                r_out_valid;

    // result registers
    logic [ENTRY_W-1:0]   r_cell;
    logic [CUR_ROW_W-1:0] r_o_row;
    logic [CUR_COL_W-1:0] r_o_col;
    logic [ENTRY_W-1:0]   r_o_cell;
    logic                 r_o_scr;

    logic [NW-1:0]       cnt_load;
    logic                at_last_col;
    logic                at_bottom;
    logic [AW-1:0]       cur_addr;
    logic [AW-1:0]       cell_addr;
    logic                rd_in_range;
    logic [CHAR_W-1:0]   store_ch;
    logic [IW-1:0]       idx_prev;
    logic [IW:0]         scroll_src;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    assign at_last_col = (r_col == CW'(COLUMNS - 1));
    assign at_bottom   = (r_row == RW'(ROWS - 1));
    assign cur_addr    = AW'(r_row) * AW'(COLUMNS) + AW'(r_col);
    assign rd_in_range = (32'(r_rrow) < ROWS) && (32'(r_rcol) < COLUMNS);
    assign cell_addr   = rd_in_range ? (AW'(r_rrow) * AW'(COLUMNS) + AW'(r_rcol)) : '0;
    assign store_ch    = (r_char == CH_TAB) ? CH_BLANK : r_char;
    assign idx_prev    = r_idx - IW'(1);
    assign scroll_src  = {1'b0, r_idx} + (IW + 1)'(COLUMNS);

    always_comb begin
        if (i_char_code == CH_TAB) begin
            cnt_load = NW'(TAB_SPACES);
        end else if (i_char_code == CH_NL) begin
            cnt_load = '0;
        end else begin
            cnt_load = NW'(1);
        end
    end

    // write port: cursor cell, sweep address, or one row up during a scroll
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {r_attr, CH_BLANK};
        case (i_cmd)
            CMD_STORE: begin
                ram_we    = 1'b1;
                ram_wdata = {r_attr, store_ch};
            end
            CMD_BLANK: begin
                ram_we = 1'b1;
            end
            CMD_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
            end
            CMD_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx[AW-1:0];
                ram_wdata = {ATTR_RESET, CH_BLANK};
            end
            CMD_SCROLL: begin
                // write trails the registered read; the last row gets blanks
                ram_we    = (r_idx != '0);
                ram_waddr = idx_prev[AW-1:0];
                if (idx_prev < IW'(CELLS - COLUMNS)) begin
                    ram_wdata = ram_rdata;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (i_cmd == CMD_SCROLL) begin
            ram_raddr = (scroll_src < (IW + 1)'(CELLS)) ? scroll_src[AW-1:0] : '0;
        end else begin
            ram_raddr = cell_addr;
        end
    end

    tmtw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_scr       <= 1'b0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_attr <= i_cfg_data;
            end
            if (i_cmd == CMD_FIN) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd)
                CMD_LATCH: begin
                    r_cnt <= cnt_load;
                    r_idx <= '0;
                    r_scr <= 1'b0;
                end
                CMD_CR: begin
                    r_col <= '0;
                end
                CMD_BS: begin
                    if (r_col != '0) begin
                        r_col <= r_col - CW'(1);
                    end else begin
                        r_row <= r_row - RW'(1);
                        r_col <= CW'(COLUMNS - 1);
                    end
                end
                CMD_STORE: begin
                    r_cnt <= r_cnt - NW'(1);
                    // hold the column at the row end; the line feed resets it
                    if (!at_last_col) begin
                        r_col <= r_col + CW'(1);
                    end
                end
                CMD_NL: begin
                    r_col <= '0;
                    r_idx <= '0;
                    if (!at_bottom) begin
                        r_row <= r_row + RW'(1);
                    end
                end
                CMD_SCROLL: begin
                    r_idx <= r_idx + IW'(1);
                    r_scr <= 1'b1;
                end
                CMD_CLEAR: begin
                    r_idx <= r_idx + IW'(1);
                    r_row <= '0;
                    r_col <= '0;
                end
                CMD_INIT: begin
                    r_idx <= r_idx + IW'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LATCH: begin
                r_op   <= i_op;
                r_char <= i_char_code;
                r_rrow <= i_read_row;
                r_rcol <= i_read_col;
                r_cell <= '0;
            end
            CMD_CAP: begin
                r_cell <= rd_in_range ? ram_rdata : '0;
            end
            CMD_FIN: begin
                r_o_row  <= CUR_ROW_W'(r_row);
                r_o_col  <= CUR_COL_W'(r_col);
                r_o_cell <= r_cell;
                r_o_scr  <= r_scr;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.op          = r_op;
        o_stat.is_nl       = (r_char == CH_NL);
        o_stat.is_cr       = (r_char == CH_CR);
        o_stat.is_bs       = (r_char == CH_BS);
        o_stat.at_origin   = (r_row == '0) && (r_col == '0);
        o_stat.at_last_col = at_last_col;
        o_stat.at_bottom   = at_bottom;
        o_stat.cnt_one     = (r_cnt == NW'(1));
        o_stat.cnt_zero    = (r_cnt == '0);
        o_stat.sweep_last  = (r_idx == IW'(CELLS - 1));
        o_stat.scroll_last = (r_idx == IW'(CELLS));
        o_stat.out_busy    = r_out_valid && i_out_stall;
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_cell_entry = r_o_cell;
    assign o_scrolled   = r_o_scr;

endmodule
`default_nettype wire

>>> design/tmtw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_ctrl
// Sequencer of the terminal writer: decodes each item and steps the datapath
// through stores, line feeds, scroll and clear sweeps, reads and the result.
// ----------------------------------------------------------------------------
module tmtw_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output tmtw_pkg::t_dp_cmd       o_cmd,
    input  wire tmtw_pkg::t_dp_stat i_stat
);

    import tmtw_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_INIT   = 4'd0;
    localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
    localparam logic [ST_W-1:0] S_DECODE = 4'd2;
    localparam logic [ST_W-1:0] S_STORE  = 4'd3;
    localparam logic [ST_W-1:0] S_NL     = 4'd4;
    localparam logic [ST_W-1:0] S_SCROLL = 4'd5;
    localparam logic [ST_W-1:0] S_AFTER  = 4'd6;
    localparam logic [ST_W-1:0] S_BLANK  = 4'd7;
    localparam logic [ST_W-1:0] S_CLEAR  = 4'd8;
    localparam logic [ST_W-1:0] S_READ   = 4'd9;
    localparam logic [ST_W-1:0] S_RCAP   = 4'd10;
    localparam logic [ST_W-1:0] S_FIN    = 4'd11;

    logic [ST_W-1:0] r_state;
    logic [ST_W-1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NOP;
        case (r_state)
            S_INIT: begin
                o_cmd = CMD_INIT;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.op)
                    OP_PUT: begin
                        if (i_stat.is_nl) begin
                            n_state = S_NL;
                        end else if (i_stat.is_cr) begin
                            o_cmd   = CMD_CR;
                            n_state = S_FIN;
                        end else if (i_stat.is_bs) begin
                            // nothing moves at the origin
                            if (i_stat.at_origin) begin
                                n_state = S_FIN;
                            end else begin
                                o_cmd   = CMD_BS;
                                n_state = S_BLANK;
                            end
                        end else begin
                            n_state = S_STORE;
                        end
                    end
                    OP_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    OP_READ: begin
                        n_state = S_READ;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_STORE: begin
                o_cmd = CMD_STORE;
                if (i_stat.at_last_col) begin
                    n_state = S_NL;
                end else if (i_stat.cnt_one) begin
                    n_state = S_FIN;
                end
            end
            S_NL: begin
                o_cmd   = CMD_NL;
                n_state = i_stat.at_bottom ? S_SCROLL : S_AFTER;
            end
            S_SCROLL: begin
                o_cmd = CMD_SCROLL;
                if (i_stat.scroll_last) begin
                    n_state = S_AFTER;
                end
            end
            S_AFTER: begin
                // continue a tab that wrapped
                n_state = i_stat.cnt_zero ? S_FIN : S_STORE;
            end
            S_BLANK: begin
                o_cmd   = CMD_BLANK;
                n_state = S_FIN;
            end
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_stat.sweep_last) begin
                    n_state = S_FIN;
                end
            end
            S_READ: begin
                n_state = S_RCAP;
            end
            S_RCAP: begin
                o_cmd   = CMD_CAP;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd   = CMD_FIN;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/tmtw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_checker
// Port-level checks of the terminal writer, bound to the top level.
// ----------------------------------------------------------------------------
module tmtw_checker #(
    parameter int COLUMNS = tmtw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tmtw_pkg::DEF_ROWS
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [tmtw_pkg::CUR_ROW_W-1:0] o_cursor_row,
    input wire logic [tmtw_pkg::CUR_COL_W-1:0] o_cursor_col,
    input wire logic [tmtw_pkg::ENTRY_W-1:0]   o_cell_entry,
    input wire logic                           o_scrolled
);

    import tmtw_pkg::*;

    // a result waiting on a stall holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_row)
            && $stable(o_cursor_col) && $stable(o_cell_entry) && $stable(o_scrolled))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_cursor_row) < ROWS) && (32'(o_cursor_col) < COLUMNS))
        else $error("cursor out of screen");

    // a scroll leaves the cursor on the bottom row
    a_scroll_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scrolled |-> o_cursor_row == CUR_ROW_W'(ROWS - 1))
        else $error("scrolled but cursor not on bottom row");

endmodule

bind text_mode_terminal_writer tmtw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tmtw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_cursor_row (o_cursor_row),
    .o_cursor_col (o_cursor_col),
    .o_cell_entry (o_cell_entry),
    .o_scrolled   (o_scrolled)
);
`default_nettype wire
